@@ design/mbr_pkg.sv @@
// ----------------------------------------------------------------------------
// mbr_pkg
// Types and constants shared by the MBR partition table parser modules.
// ----------------------------------------------------------------------------
package mbr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned POS_W     = 9;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned SLOT_W    = 2;
  localparam int unsigned NUM_SLOTS = 4;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned OUT_DATA_W = 80;

  localparam logic [POS_W-1:0]  TABLE_BASE = 9'd446;
  localparam logic [POS_W-1:0]  SIG_LO_POS = 9'd510;
  localparam logic [POS_W-1:0]  SIG_HI_POS = 9'd511;
  localparam logic [BYTE_W-1:0] SIG_LO     = 8'h55;
  localparam logic [BYTE_W-1:0] SIG_HI     = 8'hAA;
  localparam logic [BYTE_W-1:0] TYPE_PROTECTIVE = 8'hEE;

  localparam logic [3:0] ENTRY_TYPE_OFS = 4'd4;

  typedef enum logic [1:0] {
    KIND_RECORD     = 2'd0,
    KIND_PROTECTIVE = 2'd1,
    KIND_BAD_SIG    = 2'd2,
    KIND_EMPTY      = 2'd3
  } result_kind_t;

  typedef struct packed {
    logic              byte_fire;
    logic              load_status;
    result_kind_t      status_kind;
    logic              load_record;
    logic [SLOT_W-1:0] slot;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_byte;
    logic sig_good;
    logic protective;
    logic any_record;
    logic out_free;
    logic rec_emit;
    logic rec_last;
  } dp_status_t;

endpackage

@@ design/mbr_ctrl.sv @@
// ----------------------------------------------------------------------------
// mbr_ctrl
// Controller: byte intake handshake, end-of-sector decision and slot scan.
// ----------------------------------------------------------------------------
module mbr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mbr_pkg::dp_status_t status,
  output mbr_pkg::ctrl_cmd_t  cmd
);
  import mbr_pkg::*;

  typedef enum logic {
    ST_BYTES,
    ST_SCAN
  } state_t;

  state_t            state;
  logic [SLOT_W-1:0] slot;
  logic              final_fire;
  logic              scan_step;
  logic              scan_done;

  always_comb begin
    in_ready = (state == ST_BYTES) && (!status.last_byte || status.out_free);
    cmd.byte_fire = in_valid && in_ready;
    final_fire = cmd.byte_fire && status.last_byte;
    cmd.load_status = final_fire &&
                      (!status.sig_good || status.protective || !status.any_record);
    priority if (!status.sig_good) begin
      cmd.status_kind = KIND_BAD_SIG;
    end else if (status.protective) begin
      cmd.status_kind = KIND_PROTECTIVE;
    end else begin
      cmd.status_kind = KIND_EMPTY;
    end
    scan_step = (state == ST_SCAN) && status.out_free;
    cmd.load_record = scan_step && status.rec_emit;
    scan_done = (slot == SLOT_W'(NUM_SLOTS - 1)) || (status.rec_emit && status.rec_last);
    cmd.slot = slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_BYTES;
      slot  <= '0;
    end else begin
      unique case (state)
        ST_BYTES: begin
          if (final_fire && !cmd.load_status) begin
            state <= ST_SCAN;
            slot  <= '0;
          end
        end
        ST_SCAN: begin
          if (scan_step) begin
            if (scan_done) begin
              state <= ST_BYTES;
            end else begin
              slot <= slot + 1'b1;
            end
          end
        end
        default: state <= ST_BYTES;
      endcase
    end
  end

endmodule

@@ design/mbr_dp.sv @@
// ----------------------------------------------------------------------------
// mbr_dp
// Datapath: byte position, table entry fields, signature flags, record
// count and the output register.
// ----------------------------------------------------------------------------
module mbr_dp #(
  parameter int unsigned MAX_PARTITIONS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [mbr_pkg::BYTE_W-1:0]        sector_byte,
  input  logic                              restart_scan,
  input  mbr_pkg::ctrl_cmd_t                cmd,
  output mbr_pkg::dp_status_t               status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_kind,
  output logic                              out_last,
  output logic [mbr_pkg::OUT_DATA_W-1:0]    out_data
);
  import mbr_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_PARTITIONS + 1);
  localparam int unsigned WIDE_W = CNT_W + IDX_W;
  localparam logic [CNT_W-1:0] CNT_MAX      = CNT_W'(MAX_PARTITIONS);
  localparam logic [CNT_W-1:0] CNT_MAX_LESS = CNT_W'(MAX_PARTITIONS - 1);

  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  off;
  logic              in_table;
  logic              sig_ok;
  logic              prot_seen;
  logic [CNT_W-1:0]  count;
  logic [WIDE_W-1:0] count_wide;

  logic [BYTE_W-1:0] slot_type [NUM_SLOTS];
  logic [WORD_W-1:0] slot_lba  [NUM_SLOTS];
  logic [WORD_W-1:0] slot_cnt  [NUM_SLOTS];

  logic [NUM_SLOTS-1:0] qual;
  logic                 later_qual;
  logic                 below_cap;

  always_comb begin
    off = pos - TABLE_BASE;
    in_table = (pos >= TABLE_BASE) && (pos < SIG_LO_POS);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      qual[i] = (slot_type[i] != '0) && (slot_cnt[i] != '0);
    end
    later_qual = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (SLOT_W'(i) > cmd.slot && qual[i]) begin
        later_qual = 1'b1;
      end
    end
    below_cap = count < CNT_MAX;
    count_wide = {{IDX_W{1'b0}}, count};

    status.last_byte  = (pos == SIG_HI_POS);
    status.sig_good   = sig_ok && (sector_byte == SIG_HI);
    status.protective = prot_seen;
    status.any_record = (qual != '0) && below_cap;
    status.out_free   = !out_valid || out_ready;
    status.rec_emit   = qual[cmd.slot] && below_cap;
    status.rec_last   = (count >= CNT_MAX_LESS) || !later_qual;
  end

  // position, flags and count
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      sig_ok    <= 1'b0;
      prot_seen <= 1'b0;
      count     <= '0;
    end else begin
      if (cmd.byte_fire) begin
        pos <= pos + 1'b1;
        if (pos == '0) begin
          sig_ok    <= 1'b0;
          prot_seen <= 1'b0;
          if (restart_scan) begin
            count <= '0;
          end
        end
        if (in_table && off[3:0] == ENTRY_TYPE_OFS && sector_byte == TYPE_PROTECTIVE) begin
          prot_seen <= 1'b1;
        end
        if (pos == SIG_LO_POS) begin
          sig_ok <= (sector_byte == SIG_LO);
        end
      end
      if (cmd.load_record) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_fire && in_table) begin
      if (off[3:0] == ENTRY_TYPE_OFS) begin
        slot_type[off[5:4]] <= sector_byte;
      end
      if (off[3:2] == 2'd2) begin
        slot_lba[off[5:4]][off[1:0]*BYTE_W +: BYTE_W] <= sector_byte;
      end
      if (off[3:2] == 2'd3) begin
        slot_cnt[off[5:4]][off[1:0]*BYTE_W +: BYTE_W] <= sector_byte;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_status || cmd.load_record) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_status) begin
      out_kind <= cmd.status_kind;
      out_last <= 1'b1;
      out_data <= '0;
    end else if (cmd.load_record) begin
      out_kind <= KIND_RECORD;
      out_last <= status.rec_last;
      out_data <= {1'b0, slot_cnt[cmd.slot], slot_lba[cmd.slot], slot_type[cmd.slot],
                   cmd.slot, count_wide[IDX_W-1:0]};
    end
  end

endmodule

@@ design/mbr_partition_table_parser.sv @@
// ----------------------------------------------------------------------------
// mbr_partition_table_parser
// Parses sector zero of a disk, one byte per transaction, and reports the
// MBR partition records or a status result at the end of each sector.
// ----------------------------------------------------------------------------
// throughput: one byte per cycle outside the slot scan; after byte 511 the slot scan
//   steps through the table slots, waiting while a result is held, and accepts no byte
// output: a status result is registered as byte 511 is accepted, a record as its slot is scanned
// output register decouples sides; byte 511 waits only while a result is held
// reset: synchronous, clears position, flags, record count and output valid;
//   the stored table fields are not cleared
module mbr_partition_table_parser #(
  parameter int unsigned MAX_PARTITIONS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // sector_byte
  input  logic [0:0]  s_axis_tuser,  // restart_scan
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // partition_index, table_slot, part_type,
                                     // first_lba, sector_total, zero pad
  output logic [1:0]  m_axis_tuser,  // result_kind
  output logic        m_axis_tlast   // last_of_run
);
  import mbr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mbr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mbr_dp #(
    .MAX_PARTITIONS (MAX_PARTITIONS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .sector_byte  (s_axis_tdata),
    .restart_scan (s_axis_tuser[0]),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_kind     (m_axis_tuser),
    .out_last     (m_axis_tlast),
    .out_data     (m_axis_tdata)
  );

endmodule

@@ design/mbr_checker.sv @@
// ----------------------------------------------------------------------------
// mbr_checker
// Port-level assertions for the MBR partition table parser.
// ----------------------------------------------------------------------------
module mbr_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import mbr_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // status results end the run with empty data
  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != KIND_RECORD |-> m_axis_tlast && m_axis_tdata == '0)
    else $error("status result malformed");

  // records only for entries with nonzero type and count
  a_record_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_RECORD |->
      m_axis_tdata[14:7] != 8'h00 && m_axis_tdata[78:47] != 32'h0)
    else $error("record for empty entry");

  // protective entries never yield records
  a_record_not_protective: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_RECORD |-> m_axis_tdata[14:7] != TYPE_PROTECTIVE)
    else $error("record for protective entry");

endmodule

bind mbr_partition_table_parser mbr_checker u_mbr_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

@@ dv/tb_mbr_partition_table_parser.sv @@
// ----------------------------------------------------------------------------
// tb_mbr_partition_table_parser
// Streams whole 512-byte sectors into the parser and predicts the partition
// records and status results of each one. Directed sectors cover signature
// faults, protective entries, empty tables, field extremes and the record
// cap. Random sectors follow under three handshake idling mixes, with one
// long output hold-off in the first and last. Every accepted output
// transaction is compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_mbr_partition_table_parser;
  import mbr_pkg::*;

  localparam int MAX_PARTS   = 32;
  localparam int HOLD_LEN    = 2000;
  localparam int QUIET_LIMIT = 6000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    result_kind_t        kind;
    logic [IDX_W-1:0]    index;
    logic [SLOT_W-1:0]   slot;
    logic [BYTE_W-1:0]   ptype;
    logic [WORD_W-1:0]   lba;
    logic [WORD_W-1:0]   total;
    logic                run_end;
  } sector_outcome_t;

  class sector_outcome_board;
    bit [POS_W-1:0]  pos;
    bit [BYTE_W-1:0] entry_copy [64];
    bit              sig_lo_seen;
    bit              gpt_seen;
    int              rec_count;
    sector_outcome_t outcomes_due [$];
    int              fails;

    function new();
      pos = '0;
      sig_lo_seen = 1'b0;
      gpt_seen = 1'b0;
      rec_count = 0;
      fails = 0;
      foreach (entry_copy[i]) entry_copy[i] = '0;
    endfunction

    function sector_outcome_t status_of(result_kind_t k);
      sector_outcome_t r;
      r = '0;
      r.kind = k;
      r.run_end = 1'b1;
      return r;
    endfunction

    function bit [WORD_W-1:0] le_word(int base);
      return {entry_copy[base+3], entry_copy[base+2], entry_copy[base+1], entry_copy[base]};
    endfunction

    function string show(sector_outcome_t r);
      return $sformatf("kind=%0d idx=%0d slot=%0d type=%h lba=%h cnt=%h last=%b",
                       r.kind, r.index, r.slot, r.ptype, r.lba, r.total, r.run_end);
    endfunction

    function int pending();
      return outcomes_due.size();
    endfunction

    function void take_byte(bit [BYTE_W-1:0] b, bit restart);
      bit [POS_W-1:0]  at;
      bit [POS_W-1:0]  off;
      bit [BYTE_W-1:0] ptype;
      bit [WORD_W-1:0] total;
      sector_outcome_t r;
      sector_outcome_t recs [$];
      int              s;
      at = pos;
      pos = pos + 1'b1;
      if (at == '0) begin
        sig_lo_seen = 1'b0;
        gpt_seen = 1'b0;
        if (restart) rec_count = 0;
      end
      if (at >= TABLE_BASE && at < SIG_LO_POS) begin
        off = at - TABLE_BASE;
        entry_copy[off[5:0]] = b;
        if (off[3:0] == ENTRY_TYPE_OFS && b == TYPE_PROTECTIVE) gpt_seen = 1'b1;
      end else if (at == SIG_LO_POS) begin
        sig_lo_seen = (b == SIG_LO);
      end else if (at == SIG_HI_POS) begin
        if (!sig_lo_seen || b != SIG_HI) begin
          outcomes_due.push_back(status_of(KIND_BAD_SIG));
        end else if (gpt_seen) begin
          outcomes_due.push_back(status_of(KIND_PROTECTIVE));
        end else begin
          for (s = 0; s < NUM_SLOTS; s++) begin
            ptype = entry_copy[s*16 + 4];
            total = le_word(s*16 + 12);
            // qualifying entries past the cap are dropped
            if (ptype != '0 && total != '0 && rec_count < MAX_PARTS) begin
              r = '0;
              r.kind = KIND_RECORD;
              r.index = rec_count[IDX_W-1:0];
              r.slot = s[SLOT_W-1:0];
              r.ptype = ptype;
              r.lba = le_word(s*16 + 8);
              r.total = total;
              recs.push_back(r);
              rec_count++;
            end
          end
          if (recs.size() == 0) begin
            outcomes_due.push_back(status_of(KIND_EMPTY));
          end else begin
            recs[recs.size()-1].run_end = 1'b1;
            foreach (recs[i]) outcomes_due.push_back(recs[i]);
          end
        end
      end
    endfunction

    function void check_outcome(sector_outcome_t got);
      sector_outcome_t want;
      if (outcomes_due.size() == 0) begin
        fails++;
        if (fails <= REPORT_MAX) $display("unexpected result: %s", show(got));
        return;
      end
      want = outcomes_due.pop_front();
      if (want.kind !== got.kind || want.index !== got.index || want.slot !== got.slot ||
          want.ptype !== got.ptype || want.lba !== got.lba || want.total !== got.total ||
          want.run_end !== got.run_end) begin
        fails++;
        if (fails <= REPORT_MAX) begin
          $display("mismatch expected: %s", show(want));
          $display("         actual:   %s", show(got));
        end
      end
    endfunction

    function void close();
      if (outcomes_due.size() != 0) begin
        fails += outcomes_due.size();
        $display("%0d results never arrived", outcomes_due.size());
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  sector_outcome_board board = new();

  logic [7:0] sector_img [512];
  int send_idle_pct = 35;
  int recv_idle_pct = 60;
  int holds_asked = 0;
  int holds_taken = 0;
  int hold_left = 0;
  int quiet = 0;

  mbr_partition_table_parser #(
    .MAX_PARTITIONS(MAX_PARTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // output side ready, with long hold-offs on request
  always @(posedge clk) begin
    if (holds_taken != holds_asked) begin
      holds_taken = holds_asked;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    sector_outcome_t got;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) board.take_byte(s_axis_tdata, s_axis_tuser[0]);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = result_kind_t'(m_axis_tuser);
        got.index = m_axis_tdata[4:0];
        got.slot = m_axis_tdata[6:5];
        got.ptype = m_axis_tdata[14:7];
        got.lba = m_axis_tdata[46:15];
        got.total = m_axis_tdata[78:47];
        got.run_end = m_axis_tlast;
        board.check_outcome(got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function void fill_sector();
    foreach (sector_img[i]) sector_img[i] = 8'($urandom);
    sector_img[SIG_LO_POS] = SIG_LO;
    sector_img[SIG_HI_POS] = SIG_HI;
  endfunction

  function void put_entry(int s, logic [7:0] ptype, logic [31:0] lba, logic [31:0] total);
    int base;
    base = TABLE_BASE + s*16;
    sector_img[base+4] = ptype;
    for (int i = 0; i < 4; i++) begin
      sector_img[base+8+i] = lba[8*i +: 8];
      sector_img[base+12+i] = total[8*i +: 8];
    end
  endfunction

  // the first n slots qualify, the rest have a zero type
  function void make_records(int n);
    fill_sector();
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (s < n) put_entry(s, 8'($urandom_range(1, 8'hED)), $urandom, $urandom | 32'd1);
      else put_entry(s, 8'h00, $urandom, $urandom);
    end
  endfunction

  function void random_sector();
    logic [7:0]  ptype;
    logic [31:0] lba;
    logic [31:0] total;
    fill_sector();
    for (int s = 0; s < NUM_SLOTS; s++) begin
      ptype = ($urandom_range(5) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      lba = ($urandom_range(7) == 0) ? 32'hFFFF_FFFF : $urandom;
      case ($urandom_range(7))
        0, 1:    total = 32'd0;
        2:       total = 32'hFFFF_FFFF;
        default: total = $urandom;
      endcase
      put_entry(s, ptype, lba, total);
    end
    if ($urandom_range(9) == 0)
      sector_img[TABLE_BASE + 16*$urandom_range(3) + 4] = TYPE_PROTECTIVE;
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(2))
        0: sector_img[SIG_LO_POS] = SIG_LO ^ 8'($urandom_range(1, 255));
        1: sector_img[SIG_HI_POS] = SIG_HI ^ 8'($urandom_range(1, 255));
        default: begin
          sector_img[SIG_LO_POS] = SIG_LO ^ 8'($urandom_range(1, 255));
          sector_img[SIG_HI_POS] = SIG_HI ^ 8'($urandom_range(1, 255));
        end
      endcase
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= restart;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // restart on any other offset must be ignored
  task automatic send_sector(input logic restart, input int stray_pct);
    for (int i = 0; i < 512; i++)
      send_byte(sector_img[i], (i == 0) ? restart : ($urandom_range(99) < stray_pct));
  endtask

  // let the monitor note the last accepted byte before checking the queue
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int sectors,
                           input bit squeeze);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int k = 0; k < sectors; k++) begin
      if (squeeze && k == 2) holds_asked++;
      random_sector();
      send_sector($urandom_range(3) == 0, 3);
    end
    wait_drained();
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // field extremes, all four slots qualify
    fill_sector();
    put_entry(0, 8'h01, 32'h0000_0000, 32'h0000_0001);
    put_entry(1, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_entry(2, 8'h80, 32'h8000_0000, 32'h0000_0100);
    put_entry(3, 8'h7F, 32'h7FFF_FFFF, 32'h8000_0000);
    send_sector(1'b1, 0);

    // signature faults, the last one also hiding a protective entry
    make_records(4);
    sector_img[SIG_LO_POS] = 8'h54;
    send_sector(1'b0, 0);
    make_records(4);
    sector_img[SIG_HI_POS] = 8'hAB;
    send_sector(1'b0, 0);
    make_records(2);
    put_entry(3, TYPE_PROTECTIVE, $urandom, $urandom);
    sector_img[SIG_LO_POS] = 8'h00;
    sector_img[SIG_HI_POS] = 8'h00;
    send_sector(1'b0, 0);

    // protective entry in each slot
    for (int s = 0; s < NUM_SLOTS; s++) begin
      make_records(4);
      put_entry(s, TYPE_PROTECTIVE, $urandom, (s == 3) ? $urandom : 32'd0);
      send_sector(1'b0, 0);
    end

    // no qualifying entry
    make_records(0);
    send_sector(1'b0, 0);
    fill_sector();
    put_entry(0, 8'h0C, $urandom, 32'd0);
    put_entry(1, 8'hFF, $urandom, 32'd0);
    put_entry(2, 8'h00, $urandom, 32'hFFFF_FFFF);
    put_entry(3, 8'h00, $urandom, 32'd1);
    send_sector(1'b0, 0);

    // fill the record count up to the cap and past it
    make_records(4);
    send_sector(1'b1, 0);
    for (int k = 0; k < 6; k++) begin
      make_records(4);
      send_sector(1'b0, 0);
    end
    make_records(2);
    send_sector(1'b0, 0);
    make_records(4);
    send_sector(1'b0, 0);
    make_records(3);
    send_sector(1'b0, 0);
    make_records(4);
    send_sector(1'b0, 100);
    make_records(1);
    send_sector(1'b1, 0);
    wait_drained();

    run_phase(35, 60, 12, 1'b1);
    run_phase(60, 35, 12, 1'b0);
    run_phase(0, 0, 12, 1'b1);

    repeat (16) @(posedge clk);
    board.close();
    if (board.fails == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

@@ mbr_partition_table_parser.f @@
design/mbr_pkg.sv
design/mbr_ctrl.sv
design/mbr_dp.sv
design/mbr_partition_table_parser.sv
design/mbr_checker.sv
dv/tb_mbr_partition_table_parser.sv
